// ===== design/acm_pkg.sv =====
// Package for the Aho-Corasick matcher: sizes, codes and types.
// Used by aho_corasick_matcher_unit; depends on nothing else.
package acm_pkg;

  localparam int NODE_COUNT  = 4096;
  localparam int ALPHABET    = 26;
  localparam int MAX_TAGS    = 1024;
  localparam int MAX_REPORTS = 64;

  localparam int NODE_W   = $clog2(NODE_COUNT);
  localparam int CNT_W    = NODE_W + 1;
  localparam int SYM_W    = 5;
  localparam int TAG_W    = 10;
  localparam int POS_W    = 10;
  localparam int DIR_W    = 3;
  localparam int IDX_W    = $clog2(ALPHABET);
  localparam int LINK_W   = $clog2(MAX_TAGS + 1);
  localparam int TE_IDX_W = $clog2(MAX_TAGS);
  localparam int TE_W     = TAG_W + LINK_W;
  localparam int GA_DEPTH = NODE_COUNT * ALPHABET;
  localparam int GA_W     = $clog2(GA_DEPTH);
  localparam int RPT_W    = $clog2(MAX_REPORTS + 2);

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [GA_W-1:0]   gaddr_t;

  typedef enum logic [2:0] {
    REQ_PAT     = 3'd0,
    REQ_END     = 3'd1,
    REQ_BUILD   = 3'd2,
    REQ_RESTART = 3'd3,
    REQ_SCAN    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_MATCH     = 2'd0,
    ST_NODE_FULL = 2'd1,
    ST_TAG_FULL  = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_FLUSH,
    S_PAT_RD, S_PAT_CHK,
    S_TAG_RD, S_TAG_HEAD, S_TAG_WRD, S_TAG_WALK,
    S_BLD_ROOT_RD, S_BLD_ROOT, S_BLD_POP, S_BLD_CUR, S_BLD_FAIL,
    S_BLD_RT, S_BLD_RV, S_BLD_UPD,
    S_SCN_RD, S_SCN_GO, S_SCN_NODE, S_SCN_CHK, S_SCN_TRD, S_SCN_TAG
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [DIR_W-1:0] dir;
    status_t          status;
  } result_t;

  // Address of transition s of node n in the transition memory.
  function automatic gaddr_t row_addr(node_t n, logic [SYM_W-1:0] s);
    return gaddr_t'(n) * gaddr_t'(ALPHABET) + gaddr_t'(s);
  endfunction

endpackage

// ===== design/aho_corasick_matcher_unit.sv =====
// Aho-Corasick multi-pattern matcher: trie build, link pass and scan.
// Depends on acm_pkg; the trie, link, tag and queue tables sit in internal synchronous memories.

// After reset the block writes the root row and takes no transfer while it
// does so. It works on one item at a time. A pattern symbol reads its
// transition and, when it allocates a node, writes the new row one
// transition per cycle. An end-pattern item walks the tags already on that
// node and appends the new tag. A build item reads the root row, then for
// each queued node its failure link and, for each symbol, two transitions
// through the single read port of the transition memory. A scan symbol
// follows its transition, visits the nodes on the failure chain, reads the
// tags of each tagged node, and waits when results are not taken. Results go
// through an output register, so a new item is taken while a result still
// waits there. The req_type travels in in_tuser.
module aho_corasick_matcher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // req_type
  // symbol[4:0], word_tag[14:5], row[24:15], col[34:25], direction[37:35]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // match_tag[9:0], match_row[19:10], match_col[29:20], match_dir[32:30],
  // status[34:33]
  output logic [39:0] out_tdata,
  output logic        out_tlast
);
  import acm_pkg::*;

  // Memories.
  logic [NODE_W-1:0] gt_mem [GA_DEPTH];
  logic [NODE_W-1:0] fl_mem [NODE_COUNT];
  logic              rp_mem [NODE_COUNT];
  logic [LINK_W-1:0] th_mem [NODE_COUNT];
  logic [TE_W-1:0]   te_mem [MAX_TAGS];
  logic [NODE_W-1:0] bq_mem [NODE_COUNT];

  logic gt_re, gt_we, fl_re, fl_we, rp_re, rp_we, th_re, th_we;
  logic te_re, te_we, bq_re, bq_we;
  gaddr_t gt_raddr, gt_waddr;
  node_t  gt_wdata, fl_raddr, fl_waddr, fl_wdata, rp_raddr, rp_waddr;
  node_t  th_raddr, th_waddr, bq_wdata;
  logic   rp_wdata;
  logic [LINK_W-1:0]   th_wdata;
  logic [TE_IDX_W-1:0] te_raddr, te_waddr;
  logic [TE_W-1:0]     te_wdata;
  logic [NODE_W-1:0]   bq_raddr, bq_waddr;

  node_t             gt_q_r, fl_q_r;
  logic              rp_q_r;
  logic [LINK_W-1:0] th_q_r;
  logic [TE_W-1:0]   te_q_r;
  node_t             bq_q_r;

  always_ff @(posedge clk) begin
    if (gt_we) gt_mem[gt_waddr] <= gt_wdata;
    if (gt_re) gt_q_r <= gt_mem[gt_raddr];
  end
  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
    if (fl_re) fl_q_r <= fl_mem[fl_raddr];
  end
  always_ff @(posedge clk) begin
    if (rp_we) rp_mem[rp_waddr] <= rp_wdata;
    if (rp_re) rp_q_r <= rp_mem[rp_raddr];
  end
  always_ff @(posedge clk) begin
    if (th_we) th_mem[th_waddr] <= th_wdata;
    if (th_re) th_q_r <= th_mem[th_raddr];
  end
  always_ff @(posedge clk) begin
    if (te_we) te_mem[te_waddr] <= te_wdata;
    if (te_re) te_q_r <= te_mem[te_raddr];
  end
  always_ff @(posedge clk) begin
    if (bq_we) bq_mem[bq_waddr] <= bq_wdata;
    if (bq_re) bq_q_r <= bq_mem[bq_raddr];
  end

  // Control and working registers.
  state_t state_r, state_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [POS_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [DIR_W-1:0] dir_r, dir_nxt;
  node_t nc_r, nc_nxt, ins_r, ins_nxt, scan_r, scan_nxt;
  node_t cur_r, cur_nxt, f_r, f_nxt, t_r, t_nxt, init_node_r, init_node_nxt;
  logic [LINK_W-1:0] tc_r, tc_nxt, p_r, p_nxt, guard_r, guard_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  qh_r, qh_nxt, qt_r, qt_nxt, steps_r, steps_nxt;
  logic [RPT_W-1:0]  total_r, total_nxt;

  // One pending result is held back until it is known whether it is last.
  logic    pend_vld_r;
  result_t pend_r;
  logic    out_vld_r, out_last_r;
  result_t out_r;

  logic    can_push, emit_v, stall, flush_go, push_pend;
  result_t emit_res, push_res;
  logic [LINK_W-1:0] link;
  logic [SYM_W-1:0]  in_sym;

  assign in_sym   = in_tdata[4:0];
  assign link     = te_q_r[TAG_W +: LINK_W];
  assign can_push = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    emit_v   = 1'b0;
    emit_res = '{tag: te_q_r[TAG_W-1:0], row: row_r, col: col_r, dir: dir_r,
                 status: ST_MATCH};
    case (state_r)
      S_SCN_TAG: emit_v = (total_r < RPT_W'(MAX_REPORTS));
      S_PAT_CHK: begin
        if (gt_q_r == '0 && !(CNT_W'(nc_r) + 1'b1 < CNT_W'(NODE_COUNT))) begin
          emit_v   = 1'b1;
          emit_res = '{tag: '0, row: '0, col: '0, dir: '0, status: ST_NODE_FULL};
        end
      end
      S_TAG_RD: begin
        if (!(tc_r < LINK_W'(MAX_TAGS))) begin
          emit_v   = 1'b1;
          emit_res = '{tag: '0, row: '0, col: '0, dir: '0, status: ST_TAG_FULL};
        end
      end
      default: ;
    endcase
  end

  assign stall     = emit_v && pend_vld_r && !can_push;
  assign flush_go  = (state_r == S_FLUSH) && (!pend_vld_r || can_push);
  assign push_pend = pend_vld_r && can_push && ((emit_v) || (state_r == S_FLUSH));

  always_comb begin
    push_res = pend_r;
    if (state_r == S_FLUSH && total_r > RPT_W'(MAX_REPORTS))
      push_res = '{tag: '0, row: '0, col: '0, dir: '0, status: ST_TRUNC};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (idx_r == IDX_W'(ALPHABET - 1)) state_nxt = S_FLUSH;
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            REQ_PAT:   state_nxt = (in_sym < SYM_W'(ALPHABET)) ? S_PAT_RD : S_FLUSH;
            REQ_END:   state_nxt = S_TAG_RD;
            REQ_BUILD: state_nxt = S_BLD_ROOT_RD;
            REQ_SCAN:  state_nxt = (in_sym < SYM_W'(ALPHABET)) ? S_SCN_RD : S_FLUSH;
            default:   state_nxt = S_FLUSH;
          endcase
        end
      end
      S_FLUSH: if (flush_go) state_nxt = S_IDLE;
      S_PAT_RD: state_nxt = S_PAT_CHK;
      S_PAT_CHK: begin
        if (gt_q_r == '0 && CNT_W'(nc_r) + 1'b1 < CNT_W'(NODE_COUNT))
          state_nxt = S_INIT;
        else
          state_nxt = S_FLUSH;
      end
      S_TAG_RD: state_nxt = (tc_r < LINK_W'(MAX_TAGS)) ? S_TAG_HEAD : S_FLUSH;
      S_TAG_HEAD: state_nxt = (th_q_r == '0) ? S_FLUSH : S_TAG_WRD;
      S_TAG_WRD: state_nxt = S_TAG_WALK;
      S_TAG_WALK: begin
        if (link != '0 && guard_r < LINK_W'(MAX_TAGS) && link <= LINK_W'(MAX_TAGS))
          state_nxt = S_TAG_WRD;
        else
          state_nxt = S_FLUSH;
      end
      S_BLD_ROOT_RD: state_nxt = S_BLD_ROOT;
      S_BLD_ROOT:
        state_nxt = (idx_r == IDX_W'(ALPHABET - 1)) ? S_BLD_POP : S_BLD_ROOT_RD;
      S_BLD_POP: state_nxt = (qh_r < qt_r) ? S_BLD_CUR : S_FLUSH;
      S_BLD_CUR: state_nxt = S_BLD_FAIL;
      S_BLD_FAIL: state_nxt = S_BLD_RT;
      S_BLD_RT: state_nxt = S_BLD_RV;
      S_BLD_RV: state_nxt = S_BLD_UPD;
      S_BLD_UPD:
        state_nxt = (idx_r == IDX_W'(ALPHABET - 1)) ? S_BLD_POP : S_BLD_RT;
      S_SCN_RD: state_nxt = S_SCN_GO;
      S_SCN_GO: state_nxt = S_SCN_NODE;
      S_SCN_NODE:
        state_nxt = (cur_r == '0 || steps_r >= CNT_W'(NODE_COUNT)) ? S_FLUSH : S_SCN_CHK;
      S_SCN_CHK: begin
        if (rp_q_r)               state_nxt = S_FLUSH;
        else if (th_q_r != '0)    state_nxt = S_SCN_TRD;
        else                      state_nxt = S_SCN_NODE;
      end
      S_SCN_TRD: begin
        if (p_r != '0 && p_r <= LINK_W'(MAX_TAGS) && guard_r < LINK_W'(MAX_TAGS))
          state_nxt = S_SCN_TAG;
        else
          state_nxt = S_SCN_NODE;
      end
      S_SCN_TAG: if (!stall) state_nxt = S_SCN_TRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory controls and register updates.
  always_comb begin
    gt_re = 1'b0; gt_we = 1'b0; gt_raddr = '0; gt_waddr = '0; gt_wdata = '0;
    fl_re = 1'b0; fl_we = 1'b0; fl_raddr = '0; fl_waddr = '0; fl_wdata = '0;
    rp_re = 1'b0; rp_we = 1'b0; rp_raddr = '0; rp_waddr = '0; rp_wdata = 1'b0;
    th_re = 1'b0; th_we = 1'b0; th_raddr = '0; th_waddr = '0; th_wdata = '0;
    te_re = 1'b0; te_we = 1'b0; te_raddr = '0; te_waddr = '0; te_wdata = '0;
    bq_re = 1'b0; bq_we = 1'b0; bq_raddr = '0; bq_waddr = '0; bq_wdata = '0;
    sym_nxt = sym_r; tag_nxt = tag_r; row_nxt = row_r;
    col_nxt = col_r; dir_nxt = dir_r;
    nc_nxt = nc_r; ins_nxt = ins_r; scan_nxt = scan_r; cur_nxt = cur_r;
    f_nxt = f_r; t_nxt = t_r; init_node_nxt = init_node_r;
    tc_nxt = tc_r; p_nxt = p_r; guard_nxt = guard_r; idx_nxt = idx_r;
    qh_nxt = qh_r; qt_nxt = qt_r; steps_nxt = steps_r; total_nxt = total_r;
    case (state_r)
      S_INIT: begin
        gt_we    = 1'b1;
        gt_waddr = row_addr(init_node_r, SYM_W'(idx_r));
        if (idx_r == '0) begin
          fl_we = 1'b1; fl_waddr = init_node_r;
          rp_we = 1'b1; rp_waddr = init_node_r;
          th_we = 1'b1; th_waddr = init_node_r;
        end
        idx_nxt = (idx_r == IDX_W'(ALPHABET - 1)) ? '0 : idx_r + 1'b1;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          sym_nxt   = in_tdata[4:0];
          tag_nxt   = in_tdata[14:5];
          row_nxt   = in_tdata[24:15];
          col_nxt   = in_tdata[34:25];
          dir_nxt   = in_tdata[37:35];
          total_nxt = '0;
          idx_nxt   = '0;
          qh_nxt    = '0;
          qt_nxt    = '0;
          if (in_tuser == REQ_RESTART ||
              (in_tuser == REQ_SCAN && !(in_sym < SYM_W'(ALPHABET))))
            scan_nxt = '0;
        end
      end
      S_PAT_RD: begin
        gt_re = 1'b1; gt_raddr = row_addr(ins_r, sym_r);
      end
      S_PAT_CHK: begin
        if (gt_q_r != '0) begin
          ins_nxt = gt_q_r;
        end else if (CNT_W'(nc_r) + 1'b1 < CNT_W'(NODE_COUNT)) begin
          nc_nxt        = nc_r + 1'b1;
          ins_nxt       = nc_r + 1'b1;
          init_node_nxt = nc_r + 1'b1;
          idx_nxt       = '0;
          gt_we    = 1'b1;
          gt_waddr = row_addr(ins_r, sym_r);
          gt_wdata = nc_r + 1'b1;
        end
      end
      S_TAG_RD: begin
        if (tc_r < LINK_W'(MAX_TAGS)) begin
          te_we = 1'b1; te_waddr = tc_r[TE_IDX_W-1:0];
          te_wdata = {LINK_W'(0), tag_r};
          th_re = 1'b1; th_raddr = ins_r;
        end else begin
          ins_nxt = '0;
        end
      end
      S_TAG_HEAD: begin
        if (th_q_r == '0) begin
          th_we = 1'b1; th_waddr = ins_r; th_wdata = tc_r + 1'b1;
          tc_nxt = tc_r + 1'b1; ins_nxt = '0;
        end else begin
          p_nxt = th_q_r; guard_nxt = '0;
        end
      end
      S_TAG_WRD: begin
        te_re = 1'b1; te_raddr = TE_IDX_W'(p_r - 1'b1);
      end
      S_TAG_WALK: begin
        if (link != '0 && guard_r < LINK_W'(MAX_TAGS) && link <= LINK_W'(MAX_TAGS)) begin
          p_nxt = link; guard_nxt = guard_r + 1'b1;
        end else begin
          te_we = 1'b1; te_waddr = TE_IDX_W'(p_r - 1'b1);
          te_wdata = {tc_r + 1'b1, te_q_r[TAG_W-1:0]};
          tc_nxt = tc_r + 1'b1; ins_nxt = '0;
        end
      end
      S_BLD_ROOT_RD: begin
        gt_re = 1'b1; gt_raddr = gaddr_t'(idx_r);
      end
      S_BLD_ROOT: begin
        if (gt_q_r != '0 && qt_r < CNT_W'(NODE_COUNT)) begin
          bq_we = 1'b1; bq_waddr = qt_r[NODE_W-1:0]; bq_wdata = gt_q_r;
          qt_nxt = qt_r + 1'b1;
        end
        idx_nxt = (idx_r == IDX_W'(ALPHABET - 1)) ? '0 : idx_r + 1'b1;
      end
      S_BLD_POP: begin
        if (qh_r < qt_r) begin
          bq_re = 1'b1; bq_raddr = qh_r[NODE_W-1:0];
          qh_nxt = qh_r + 1'b1;
        end
      end
      S_BLD_CUR: begin
        cur_nxt = bq_q_r;
        fl_re = 1'b1; fl_raddr = bq_q_r;
      end
      S_BLD_FAIL: begin
        f_nxt = fl_q_r; idx_nxt = '0;
      end
      S_BLD_RT: begin
        gt_re = 1'b1; gt_raddr = row_addr(cur_r, SYM_W'(idx_r));
      end
      S_BLD_RV: begin
        t_nxt = gt_q_r;
        gt_re = 1'b1; gt_raddr = row_addr(f_r, SYM_W'(idx_r));
      end
      S_BLD_UPD: begin
        if (t_r != '0) begin
          if (qt_r < CNT_W'(NODE_COUNT)) begin
            bq_we = 1'b1; bq_waddr = qt_r[NODE_W-1:0]; bq_wdata = t_r;
            qt_nxt = qt_r + 1'b1;
          end
          fl_we = 1'b1; fl_waddr = t_r; fl_wdata = gt_q_r;
        end else begin
          gt_we = 1'b1; gt_waddr = row_addr(cur_r, SYM_W'(idx_r)); gt_wdata = gt_q_r;
        end
        idx_nxt = (idx_r == IDX_W'(ALPHABET - 1)) ? '0 : idx_r + 1'b1;
      end
      S_SCN_RD: begin
        gt_re = 1'b1; gt_raddr = row_addr(scan_r, sym_r);
      end
      S_SCN_GO: begin
        scan_nxt = gt_q_r; cur_nxt = gt_q_r; steps_nxt = '0;
      end
      S_SCN_NODE: begin
        if (!(cur_r == '0 || steps_r >= CNT_W'(NODE_COUNT))) begin
          rp_re = 1'b1; rp_raddr = cur_r;
          th_re = 1'b1; th_raddr = cur_r;
          fl_re = 1'b1; fl_raddr = cur_r;
        end
      end
      S_SCN_CHK: begin
        f_nxt = fl_q_r;
        if (!rp_q_r) begin
          if (th_q_r != '0) begin
            rp_we = 1'b1; rp_waddr = cur_r; rp_wdata = 1'b1;
            p_nxt = th_q_r; guard_nxt = '0;
          end else begin
            cur_nxt = fl_q_r; steps_nxt = steps_r + 1'b1;
          end
        end
      end
      S_SCN_TRD: begin
        if (p_r != '0 && p_r <= LINK_W'(MAX_TAGS) && guard_r < LINK_W'(MAX_TAGS)) begin
          te_re = 1'b1; te_raddr = TE_IDX_W'(p_r - 1'b1);
        end else begin
          cur_nxt = f_r; steps_nxt = steps_r + 1'b1;
        end
      end
      S_SCN_TAG: begin
        if (!stall) begin
          // The count stops one above the report limit, which marks truncation.
          if (total_r <= RPT_W'(MAX_REPORTS)) total_nxt = total_r + 1'b1;
          p_nxt = link; guard_nxt = guard_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_node_r <= '0;
      idx_r       <= '0;
      nc_r        <= '0;
      tc_r        <= '0;
      ins_r       <= '0;
      scan_r      <= '0;
      total_r     <= '0;
      qh_r        <= '0;
      qt_r        <= '0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_node_r <= init_node_nxt;
      idx_r       <= idx_nxt;
      nc_r        <= nc_nxt;
      tc_r        <= tc_nxt;
      ins_r       <= ins_nxt;
      scan_r      <= scan_nxt;
      total_r     <= total_nxt;
      qh_r        <= qh_nxt;
      qt_r        <= qt_nxt;
      if (emit_v && !stall)   pend_vld_r <= 1'b1;
      else if (push_pend)     pend_vld_r <= 1'b0;
      if (push_pend)          out_vld_r  <= 1'b1;
      else if (out_tready)    out_vld_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    tag_r   <= tag_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    dir_r   <= dir_nxt;
    cur_r   <= cur_nxt;
    f_r     <= f_nxt;
    t_r     <= t_nxt;
    p_r     <= p_nxt;
    guard_r <= guard_nxt;
    steps_r <= steps_nxt;
    if (emit_v && !stall) pend_r <= emit_res;
    if (push_pend) begin
      out_r      <= push_res;
      out_last_r <= (state_r == S_FLUSH);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_r.status, out_r.dir, out_r.col, out_r.row, out_r.tag};

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_vld_r)
    else $error("pending result left when taking a new item");
  a_tag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tc_r <= LINK_W'(MAX_TAGS))
    else $error("tag count beyond tag store");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    qh_r <= qt_r)
    else $error("build queue head passed its tail");
  a_report_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= RPT_W'(MAX_REPORTS + 1))
    else $error("report counter out of range");
`endif

endmodule
